/* sv/psb_pkg.sv */
// Package for the particle step/bounce block: field widths, config register
// codes and the stage-enable struct shared by the top level and the axis unit.
// No dependencies.
`timescale 1ns / 1ps

package psb_pkg;

	localparam int QW        = 32;   // Q16.16 word
	localparam int DT_W      = 31;   // unsigned elapsed time
	localparam int WALL_W    = 16;   // integer wall position
	localparam int FRAC_BITS = 16;
	localparam int CFG_IDX_W = 2;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_WALL_LEFT   = 2'd0,
		CFG_WALL_RIGHT  = 2'd1,
		CFG_WALL_BOTTOM = 2'd2,
		CFG_WALL_TOP    = 2'd3
	} psb_cfg_idx_t;

	// register enables of the pipeline stages behind stage 1
	typedef struct packed {
		logic en2;
		logic en3;
		logic en4;
	} psb_stall_t;

	localparam logic signed [QW-1:0] Q_MAX = {1'b0, {(QW-1){1'b1}}};
	localparam logic signed [QW-1:0] Q_MIN = {1'b1, {(QW-1){1'b0}}};

endpackage

/* sv/psb_axis.sv */
// One axis of the particle step: multiply, shift and saturating add, then
// wall compare, clamp and velocity reflection over stages 2 to 4.
// Depends on psb_pkg.
`timescale 1ns / 1ps

module psb_axis import psb_pkg::*; (
	input  logic                     clk,
	input  psb_stall_t               en,
	input  logic signed [QW-1:0]     pos_s1,
	input  logic signed [QW-1:0]     vel_s1,
	input  logic        [DT_W-1:0]   dt_s1,
	input  logic                     live_s3,
	input  logic signed [WALL_W-1:0] wall_lo,
	input  logic signed [WALL_W-1:0] wall_hi,
	output logic signed [QW-1:0]     npos_s4,
	output logic signed [QW-1:0]     nvel_s4,
	output logic                     bounce_s4
);

	localparam int PW = 2 * QW;                  // exact product width
	localparam int SW = PW - FRAC_BITS;          // shifted product plus pos

	logic signed [PW-1:0] prod_s2;
	logic signed [QW-1:0] pos_s2, vel_s2;
	logic signed [QW-1:0] p_s3, pos_s3, vel_s3;
	logic signed [SW-1:0] sum;
	logic signed [QW-1:0] p_sat;
	logic signed [QW-1:0] lo, hi, clamp_lo, clamp;
	logic                 hit;
	logic signed [QW-1:0] vel_neg;

	// stage 2: exact product vel * dt
	always_ff @(posedge clk) begin
		if (en.en2) begin
			prod_s2 <= PW'(vel_s1 * $signed({1'b0, dt_s1}));
			pos_s2  <= pos_s1;
			vel_s2  <= vel_s1;
		end
	end

	// floor shift is an arithmetic right shift; add position and saturate
	always_comb begin
		sum = SW'(pos_s2) + prod_s2[PW-1:FRAC_BITS];
		if (sum[SW-1:QW-1] == {(SW-QW+1){1'b0}} || sum[SW-1:QW-1] == {(SW-QW+1){1'b1}})
			p_sat = sum[QW-1:0];
		else if (sum[SW-1])
			p_sat = Q_MIN;
		else
			p_sat = Q_MAX;
	end

	// stage 3: moved position
	always_ff @(posedge clk) begin
		if (en.en3) begin
			p_s3   <= p_sat;
			pos_s3 <= pos_s2;
			vel_s3 <= vel_s2;
		end
	end

	// wall compare, clamp (low wall first, then high wall) and reflect
	always_comb begin
		lo       = {wall_lo, {FRAC_BITS{1'b0}}};
		hi       = {wall_hi, {FRAC_BITS{1'b0}}};
		hit      = (p_s3 <= lo) || (p_s3 > hi);
		clamp_lo = (p_s3 < lo) ? lo : p_s3;
		clamp    = (clamp_lo > hi) ? hi : clamp_lo;
		vel_neg  = (vel_s3 == Q_MIN) ? Q_MAX : -vel_s3;
	end

	// stage 4: dead particles pass through unchanged
	always_ff @(posedge clk) begin
		if (en.en4) begin
			if (!live_s3) begin
				npos_s4   <= pos_s3;
				nvel_s4   <= vel_s3;
				bounce_s4 <= 1'b0;
			end else if (hit) begin
				npos_s4   <= clamp;
				nvel_s4   <= vel_neg;
				bounce_s4 <= 1'b1;
			end else begin
				npos_s4   <= p_s3;
				nvel_s4   <= vel_s3;
				bounce_s4 <= 1'b0;
			end
		end
	end

endmodule

/* sv/particle_step_bounce_top.sv */
// Top level of the particle step/bounce block: stream ports, wall registers,
// valid pipeline and lifetime path. Depends on psb_pkg and psb_axis.
`timescale 1ns / 1ps

// Four stage registers lie between input item accept and result item valid.
// Throughput: one item per cycle; each stage register holds while the
// stage behind it is full and stalled, so a stalled output reaches s_tready
// through the enable chain in the same cycle. Reset clears the stage valid bits and loads
// the walls with left 0, right 1024, bottom -768, top 0; data registers are not reset.
module particle_step_bounce_top import psb_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	// input items
	input  logic          s_tvalid,
	output logic          s_tready,
	// pos_x[31:0], pos_y[63:32], vel_x[95:64], vel_y[127:96],
	// life_left[159:128], elapsed[190:160], zero pad[191]
	input  logic [191:0]  s_tdata,
	// result items
	output logic          m_tvalid,
	input  logic          m_tready,
	// new_pos_x[31:0], new_pos_y[63:32], new_vel_x[95:64], new_vel_y[127:96],
	// new_life[159:128]
	output logic [159:0]  m_tdata,
	// was_live[0], bounced_x[1], bounced_y[2]
	output logic [2:0]    m_tuser,
	// configuration writes
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [WALL_W-1:0]    cfg_data
);

	logic signed [WALL_W-1:0] wall_left_q, wall_right_q, wall_bottom_q, wall_top_q;

	logic v1_s1, v2_s2, v3_s3, v4_s4;
	logic en1;
	psb_stall_t en;

	logic signed [QW-1:0] px_s1, py_s1, vx_s1, vy_s1, life_s1;
	logic        [DT_W-1:0] dt_s1;
	logic signed [QW-1:0] life_s2, life_s3, life_s4;
	logic                 live_s2, live_s3, live_s4;
	logic signed [QW:0]   life_diff;
	logic signed [QW-1:0] life_next;
	logic signed [QW-1:0] npx_s4, npy_s4, nvx_s4, nvy_s4;
	logic                 bx_s4, by_s4;

	// wall registers
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wall_left_q   <= 16'sd0;
			wall_right_q  <= 16'sd1024;
			wall_bottom_q <= -16'sd768;
			wall_top_q    <= 16'sd0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (psb_cfg_idx_t'(cfg_index))
				CFG_WALL_LEFT:   wall_left_q   <= cfg_data;
				CFG_WALL_RIGHT:  wall_right_q  <= cfg_data;
				CFG_WALL_BOTTOM: wall_bottom_q <= cfg_data;
				CFG_WALL_TOP:    wall_top_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// advance a stage when it is empty or the one behind it advances
	assign en.en4   = !v4_s4 || m_tready;
	assign en.en3   = !v3_s3 || en.en4;
	assign en.en2   = !v2_s2 || en.en3;
	assign en1      = !v1_s1 || en.en2;
	assign s_tready = en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0;
			v2_s2 <= 1'b0;
			v3_s3 <= 1'b0;
			v4_s4 <= 1'b0;
		end else begin
			if (en1)    v1_s1 <= s_tvalid;
			if (en.en2) v2_s2 <= v1_s1;
			if (en.en3) v3_s3 <= v2_s2;
			if (en.en4) v4_s4 <= v3_s3;
		end
	end

	// stage 1: capture the item
	always_ff @(posedge clk) begin
		if (en1) begin
			px_s1   <= s_tdata[31:0];
			py_s1   <= s_tdata[63:32];
			vx_s1   <= s_tdata[95:64];
			vy_s1   <= s_tdata[127:96];
			life_s1 <= s_tdata[159:128];
			dt_s1   <= s_tdata[190:160];
		end
	end

	// saturating lifetime decrement
	always_comb begin
		life_diff = {life_s1[QW-1], life_s1} - $signed({2'b00, dt_s1});
		if (life_diff[QW] != life_diff[QW-1])
			life_next = life_diff[QW] ? Q_MIN : Q_MAX;
		else
			life_next = life_diff[QW-1:0];
	end

	// stages 2 to 4 of the lifetime path
	always_ff @(posedge clk) begin
		if (en.en2) begin
			live_s2 <= (life_s1 > 0);
			life_s2 <= (life_s1 > 0) ? life_next : life_s1;
		end
		if (en.en3) begin
			live_s3 <= live_s2;
			life_s3 <= life_s2;
		end
		if (en.en4) begin
			live_s4 <= live_s3;
			life_s4 <= life_s3;
		end
	end

	psb_axis u_axis_x (
		.clk       (clk),
		.en        (en),
		.pos_s1    (px_s1),
		.vel_s1    (vx_s1),
		.dt_s1     (dt_s1),
		.live_s3   (live_s3),
		.wall_lo   (wall_left_q),
		.wall_hi   (wall_right_q),
		.npos_s4   (npx_s4),
		.nvel_s4   (nvx_s4),
		.bounce_s4 (bx_s4)
	);

	psb_axis u_axis_y (
		.clk       (clk),
		.en        (en),
		.pos_s1    (py_s1),
		.vel_s1    (vy_s1),
		.dt_s1     (dt_s1),
		.live_s3   (live_s3),
		.wall_lo   (wall_bottom_q),
		.wall_hi   (wall_top_q),
		.npos_s4   (npy_s4),
		.nvel_s4   (nvy_s4),
		.bounce_s4 (by_s4)
	);

	// result item
	assign m_tvalid = v4_s4;
	assign m_tdata  = {life_s4, nvy_s4, nvx_s4, npy_s4, npx_s4};
	assign m_tuser  = {by_s4, bx_s4, live_s4};

`ifndef SYNTH
	// input side only stalls when the output register is held
	a_stall_source: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (m_tvalid && !m_tready))
		else $error("input stalled while output is free");

	// a dead particle never bounces
	a_dead_no_bounce: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tuser[0]) |-> (m_tuser[2:1] == 2'b00))
		else $error("bounce flagged on dead particle");

	// a pipeline that is full end to end and stalled refuses input
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(v1_s1 && v2_s2 && v3_s3 && v4_s4 && !m_tready) |-> !s_tready)
		else $error("full pipeline accepted an item");

	// an accepted item shows up in stage 1 on the next cycle
	a_accept_lands: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> v1_s1)
		else $error("accepted item lost at stage 1");
`endif

endmodule

/* tb/tb_particle_step_bounce_top.sv */
// Testbench for particle_step_bounce_top: directed and random particle items checked
// against a Q16.16 step-and-bounce predictor, with wall writes between phases.
// Depends on psb_pkg and the particle_step_bounce_top RTL.
`timescale 1ns / 1ps

module tb_particle_step_bounce_top;
	import psb_pkg::*;

	localparam int ONE = 1 << FRAC_BITS;

	typedef struct {
		logic signed [QW-1:0] pos_x, pos_y, vel_x, vel_y, life;
		logic [DT_W-1:0]      dt;
	} particle_t;

	typedef struct {
		logic signed [QW-1:0] pos_x, pos_y, vel_x, vel_y, life;
		logic                 was_live, bounced_x, bounced_y;
	} particle_upd_t;

	logic                 clk;
	logic                 arst_n;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [191:0]         s_tdata;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [159:0]         m_tdata;
	logic [2:0]           m_tuser;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [WALL_W-1:0]    cfg_data;

	// bench copy of the wall registers, updated on each accepted write
	logic signed [WALL_W-1:0] walls [4];
	particle_upd_t pending_updates [$];
	int err_count;
	int idle_pct;
	int stall_pct;

	particle_step_bounce_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	// stall the result side at random
	always @(negedge clk) begin
		m_tready = ($urandom_range(99) >= stall_pct);
	end

	// ---------------------------------------------------------------- predictor

	function automatic logic signed [QW-1:0] sat_q(input longint v);
		if (v > longint'(Q_MAX))
			return Q_MAX;
		if (v < longint'(Q_MIN))
			return Q_MIN;
		return QW'(v);
	endfunction

	// advance one axis and reflect off its walls; returns the bounce flag
	function automatic logic move_axis(input logic signed [QW-1:0] pos, vel,
			input logic [DT_W-1:0] dt, input logic signed [WALL_W-1:0] lo_w, hi_w,
			output logic signed [QW-1:0] npos, nvel);
		longint lo, hi, shift, p;
		lo = longint'(lo_w) * ONE;
		hi = longint'(hi_w) * ONE;
		// exact Q32.32 product, floored back to Q16.16
		shift = (longint'(vel) * longint'(dt)) >>> FRAC_BITS;
		p = longint'(sat_q(longint'(pos) + shift));
		if (p <= lo || p > hi) begin
			// raise to the low wall first, then lower to the high wall
			if (p < lo)
				p = lo;
			if (p > hi)
				p = hi;
			npos = QW'(p);
			nvel = sat_q(-longint'(vel));
			return 1'b1;
		end
		npos = QW'(p);
		nvel = vel;
		return 1'b0;
	endfunction

	function automatic particle_upd_t advance_particle(input particle_t p);
		particle_upd_t r;
		r.pos_x     = p.pos_x;
		r.pos_y     = p.pos_y;
		r.vel_x     = p.vel_x;
		r.vel_y     = p.vel_y;
		r.life      = p.life;
		r.was_live  = (p.life > 0);
		r.bounced_x = 1'b0;
		r.bounced_y = 1'b0;
		if (r.was_live) begin
			r.life = sat_q(longint'(p.life) - longint'(p.dt));
			r.bounced_x = move_axis(p.pos_x, p.vel_x, p.dt, walls[CFG_WALL_LEFT],
				walls[CFG_WALL_RIGHT], r.pos_x, r.vel_x);
			r.bounced_y = move_axis(p.pos_y, p.vel_y, p.dt, walls[CFG_WALL_BOTTOM],
				walls[CFG_WALL_TOP], r.pos_y, r.vel_y);
		end
		return r;
	endfunction

	// ---------------------------------------------------------------- checking

	function automatic void check_field(input string name, input logic signed [63:0] want,
			input logic signed [63:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			err_count++;
		end
	endfunction

	// compare each accepted result item with the oldest expectation
	always @(posedge clk) begin
		particle_upd_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_updates.size() == 0) begin
				$error("result item with no particle pending");
				err_count++;
			end else begin
				want = pending_updates.pop_front();
				check_field("new_pos_x", want.pos_x, $signed(m_tdata[31:0]));
				check_field("new_pos_y", want.pos_y, $signed(m_tdata[63:32]));
				check_field("new_vel_x", want.vel_x, $signed(m_tdata[95:64]));
				check_field("new_vel_y", want.vel_y, $signed(m_tdata[127:96]));
				check_field("new_life", want.life, $signed(m_tdata[159:128]));
				check_field("was_live", {63'd0, want.was_live}, {63'd0, m_tuser[0]});
				check_field("bounced_x", {63'd0, want.bounced_x}, {63'd0, m_tuser[1]});
				check_field("bounced_y", {63'd0, want.bounced_y}, {63'd0, m_tuser[2]});
			end
		end
	end

	// ---------------------------------------------------------------- drivers

	// offer one particle item; called and returns at a falling edge
	task automatic send_particle(input particle_t p);
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tdata  = {1'b0, p.dt, p.life, p.vel_y, p.vel_x, p.pos_y, p.pos_x};
		s_tvalid = 1'b1;
		pending_updates.push_back(advance_particle(p));
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
	endtask

	// drop valid, wait for every pending result, then let the pipeline settle
	task automatic wait_results();
		int waited;
		waited   = 0;
		s_tvalid = 1'b0;
		while (pending_updates.size() != 0 && waited < 20000) begin
			@(negedge clk);
			waited++;
		end
		if (pending_updates.size() != 0) begin
			$error("%0d result items never arrived", pending_updates.size());
			err_count += pending_updates.size();
			pending_updates.delete();
		end
		repeat (8) @(negedge clk);
	endtask

	task automatic write_wall(input psb_cfg_idx_t idx, input logic signed [WALL_W-1:0] val);
		cfg_index = idx;
		cfg_data  = val;
		cfg_valid = 1'b1;
		do @(posedge clk); while (!cfg_ready);
		walls[idx] = val;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	task automatic set_walls(input int left, right, bottom, top);
		wait_results();
		write_wall(CFG_WALL_LEFT, WALL_W'(left));
		write_wall(CFG_WALL_RIGHT, WALL_W'(right));
		write_wall(CFG_WALL_BOTTOM, WALL_W'(bottom));
		write_wall(CFG_WALL_TOP, WALL_W'(top));
	endtask

	// ---------------------------------------------------------------- stimulus

	function automatic particle_t make_particle(input logic signed [QW-1:0] px, py, vx, vy,
			lf, input logic [DT_W-1:0] dt);
		particle_t p;
		p.pos_x = px;
		p.pos_y = py;
		p.vel_x = vx;
		p.vel_y = vy;
		p.life  = lf;
		p.dt    = dt;
		return p;
	endfunction

	// position near one of the two walls or somewhere between them
	function automatic logic signed [QW-1:0] near_wall(input logic signed [WALL_W-1:0] lo,
			hi);
		int lo_i, hi_i, unit;
		lo_i = lo;
		hi_i = hi;
		case ($urandom_range(3))
			0: unit = lo_i + int'($urandom_range(8)) - 4;
			1: unit = hi_i + int'($urandom_range(8)) - 4;
			default: begin
				if (lo_i <= hi_i)
					unit = lo_i + int'($urandom_range(hi_i - lo_i));
				else
					unit = hi_i + int'($urandom_range(lo_i - hi_i));
			end
		endcase
		return QW'(longint'(unit) * ONE + longint'($urandom_range(ONE - 1)));
	endfunction

	// mostly live particles moving around the box, some fully random items
	function automatic particle_t rand_particle();
		particle_t p;
		if ($urandom_range(99) < 25)
			return make_particle($urandom, $urandom, $urandom, $urandom, $urandom,
				DT_W'($urandom));
		p.pos_x = near_wall(walls[CFG_WALL_LEFT], walls[CFG_WALL_RIGHT]);
		p.pos_y = near_wall(walls[CFG_WALL_BOTTOM], walls[CFG_WALL_TOP]);
		p.vel_x = QW'(int'($urandom_range(1 << 27)) - (1 << 26));
		p.vel_y = QW'(int'($urandom_range(1 << 27)) - (1 << 26));
		p.dt    = DT_W'($urandom_range(ONE / 4));
		if ($urandom_range(9) == 0)
			p.life = QW'(-int'($urandom_range(4 * ONE)));
		else
			p.life = QW'($urandom_range(32'h7fff_ffff, 1));
		return p;
	endfunction

	task automatic rand_walls();
		int lo_x, lo_y;
		if ($urandom_range(99) < 15) begin
			set_walls($urandom, $urandom, $urandom, $urandom);
		end else begin
			lo_x = int'($urandom_range(3000)) - 2000;
			lo_y = int'($urandom_range(3000)) - 2000;
			set_walls(lo_x, lo_x + int'($urandom_range(2000, 1)),
				lo_y, lo_y + int'($urandom_range(2000, 1)));
		end
	endtask

	// ---------------------------------------------------------------- tests

	// reset walls: dead items, wall contacts, saturation and rounding
	task automatic test_reset_walls();
		send_particle(make_particle(12 * ONE, -5 * ONE, 3 * ONE, -2 * ONE, 0, ONE / 2));
		send_particle(make_particle(Q_MAX, Q_MIN, Q_MIN, Q_MAX, Q_MIN, 31'h7fff_ffff));
		send_particle(make_particle(-1, 1, 1, -1, -1, 1));
		send_particle(make_particle(10 * ONE, -10 * ONE, 7 * ONE, 7 * ONE, 1, 0));
		// exactly on the low wall counts as a hit
		send_particle(make_particle(0, -10 * ONE, 5 * ONE, 0, ONE, 0));
		send_particle(make_particle(ONE, -768 * ONE, 0, -3 * ONE, ONE, 0));
		// exactly on the high wall does not
		send_particle(make_particle(1024 * ONE, 0, 1, 1, ONE, 0));
		// saturated motion, then clamp; most negative velocity negates to max
		send_particle(make_particle(Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, 31'h7fff_ffff));
		send_particle(make_particle(Q_MIN, Q_MIN, Q_MIN, Q_MIN, ONE, 31'h7fff_ffff));
		// floor rounding of negative and positive fractional steps
		send_particle(make_particle(5 * ONE, -5 * ONE, -1, -1, ONE, 1));
		send_particle(make_particle(5 * ONE, -5 * ONE, 3, 3, ONE, ONE / 2));
		send_particle(make_particle(2000 * ONE, -1000 * ONE, ONE, ONE, 2 * ONE, ONE));
		send_particle(make_particle(1023 * ONE, -ONE, 4 * ONE, 8 * ONE, 5 * ONE, ONE / 4));
		send_particle(make_particle(100 * ONE, -100 * ONE, ONE, -ONE, 1, 31'h7fff_ffff));
		send_particle(make_particle(500 * ONE, -ONE, -ONE, Q_MIN, 3 * ONE, 31'h7fff_ffff));
		repeat (6) send_particle(rand_particle());
	endtask

	// widest box and the most extreme register values
	task automatic test_wall_extremes();
		set_walls(-32768, 32767, -32768, 32767);
		send_particle(make_particle(Q_MIN, Q_MAX, -ONE, ONE, ONE, ONE));
		send_particle(make_particle(0, 0, 0, 0, ONE, 0));
		send_particle(make_particle(Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX, 31'h7fff_ffff));
		repeat (8) send_particle(rand_particle());
	endtask

	// low wall above high wall, and a zero-size box
	task automatic test_crossed_walls();
		set_walls(100, -100, 50, -50);
		send_particle(make_particle(0, 0, ONE, -ONE, ONE, ONE));
		repeat (8) send_particle(rand_particle());
		set_walls(0, 0, 0, 0);
		send_particle(make_particle(0, 0, 0, 0, ONE, 0));
		repeat (8) send_particle(rand_particle());
		set_walls(32767, -32768, 32767, -32768);
		send_particle(make_particle(Q_MAX, Q_MIN, Q_MIN, Q_MAX, ONE, ONE));
		repeat (4) send_particle(rand_particle());
	endtask

	// random traffic under each idling pattern, new walls per phase
	task automatic test_random_traffic();
		int idle_by_phase [4];
		int stall_by_phase [4];
		idle_by_phase  = '{0, 60, 0, 31};
		stall_by_phase = '{0, 0, 60, 31};
		for (int ph = 0; ph < 4; ph++) begin
			rand_walls();
			idle_pct  = idle_by_phase[ph];
			stall_pct = stall_by_phase[ph];
			repeat (400) send_particle(rand_particle());
		end
		set_walls(0, 1024, -768, 0);
		idle_pct  = 0;
		stall_pct = 0;
	endtask

	// ---------------------------------------------------------------- sequence

	initial begin
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		m_tready  = 1'b1;
		cfg_valid = 1'b0;
		cfg_index = CFG_WALL_LEFT;
		cfg_data  = '0;
		err_count = 0;
		idle_pct  = 0;
		stall_pct = 0;
		walls[CFG_WALL_LEFT]   = 0;
		walls[CFG_WALL_RIGHT]  = 1024;
		walls[CFG_WALL_BOTTOM] = -768;
		walls[CFG_WALL_TOP]    = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_reset_walls();
		test_wall_extremes();
		test_crossed_walls();
		test_random_traffic();
		wait_results();

		if (err_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

	// hard stop if the run hangs
	initial begin
		#4_000_000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
